[sv/ihp_pkg.sv]
// shared types and constants of the indexed max heap
package ihp_pkg;

  localparam int unsigned NODE_W    = 12;
  localparam int unsigned KEY_W     = 16;
  localparam int unsigned CNT_OUT_W = 13;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned STATUS_W  = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT  = 2'd0,
    MODE_EXTRACT = 2'd1,
    MODE_REMOVE  = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_DUP    = 3'd3,
    ST_ABSENT = 3'd4
  } status_e;

  // one heap slot: node id and its key
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [KEY_W-1:0]  key;
  } entry_t;

  // one result beat
  typedef struct packed {
    logic [NODE_W-1:0]    out_node;
    logic [KEY_W-1:0]     out_key;
    logic                 heap_empty;
    logic [CNT_OUT_W-1:0] entry_count;
    logic [STATUS_W-1:0]  status;
  } res_t;

endpackage

[sv/ihp_in_if.sv]
// request channel of the indexed max heap
interface ihp_in_if;
  logic                          valid;
  logic                          ready;
  logic [ihp_pkg::MODE_W-1:0]    mode;
  logic [ihp_pkg::NODE_W-1:0]    node_id;
  logic [ihp_pkg::KEY_W-1:0]     key;

  modport source (output valid, mode, node_id, key, input ready);
  modport sink   (input valid, mode, node_id, key, output ready);
endinterface

[sv/ihp_out_if.sv]
// result channel of the indexed max heap
interface ihp_out_if;
  logic                          valid;
  logic                          ready;
  logic [ihp_pkg::NODE_W-1:0]    out_node;
  logic [ihp_pkg::KEY_W-1:0]     out_key;
  logic                          heap_empty;
  logic [ihp_pkg::CNT_OUT_W-1:0] entry_count;
  logic [ihp_pkg::STATUS_W-1:0]  status;

  modport source (output valid, out_node, out_key, heap_empty, entry_count, status,
                  input ready);
  modport sink   (input valid, out_node, out_key, heap_empty, entry_count, status,
                  output ready);
endinterface

[sv/indexed_max_heap.sv]
// indexed max heap top level: rams, sequencer and result register
//
// usage:
//   item_i carries one request beat: mode (insert, extract maximum, remove
//   named node), node_id and key. result_o returns exactly one beat per
//   request: the removed entry or the current top, the entry count, an
//   empty flag and a status code.
//   the heap lives in one ram of NODES slots, the node-to-slot map in a
//   second ram of NODES entries; both have a registered read.
//   one request is worked at a time. insert looks up the node, then climbs
//   level by level; extract takes the root, loads the last entry into it
//   and descends, reading the left and then the right child per level;
//   remove first raises the node to the root, then continues as extract.
//   after reset the slot map is cleared, one entry a cycle, over all NODES
//   entries; item_i.ready stays low during that pass.
//   a finished result sits in an output register; if the receiver stalls,
//   the next request is still worked and holds only until that register
//   frees up.
module indexed_max_heap #(
  parameter int unsigned NODES = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ihp_in_if.sink     item_i,
  ihp_out_if.source  result_o
);

  localparam int unsigned SLOT_W = $clog2(NODES);
  localparam int unsigned EW     = $bits(ihp_pkg::entry_t);

  // heap ram signals
  logic [SLOT_W-1:0] hr_addr, hw_addr;
  logic              hw_en;
  ihp_pkg::entry_t   hr_data, hw_data;
  logic [EW-1:0]     hr_raw;

  // slot map ram signals: present bit and slot
  logic [SLOT_W-1:0] pr_addr, pw_addr;
  logic              pw_en;
  logic [SLOT_W:0]   pr_data, pw_data;

  // result handoff
  ihp_pkg::res_t     res, out_q;
  logic              res_valid, res_ready;
  logic              out_valid_q;

  ihp_ram #(
    .WIDTH (EW),
    .DEPTH (NODES)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (hw_en),
    .waddr_i (hw_addr),
    .wdata_i (hw_data),
    .raddr_i (hr_addr),
    .rdata_o (hr_raw)
  );

  assign hr_data = ihp_pkg::entry_t'(hr_raw);

  ihp_ram #(
    .WIDTH (SLOT_W + 1),
    .DEPTH (NODES)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pw_en),
    .waddr_i (pw_addr),
    .wdata_i (pw_data),
    .raddr_i (pr_addr),
    .rdata_o (pr_data)
  );

  ihp_ctrl #(
    .NODES (NODES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .in_mode_i   (item_i.mode),
    .in_node_i   (item_i.node_id),
    .in_key_i    (item_i.key),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .hr_addr_o   (hr_addr),
    .hr_data_i   (hr_data),
    .hw_en_o     (hw_en),
    .hw_addr_o   (hw_addr),
    .hw_data_o   (hw_data),
    .pr_addr_o   (pr_addr),
    .pr_data_i   (pr_data),
    .pw_en_o     (pw_en),
    .pw_addr_o   (pw_addr),
    .pw_data_o   (pw_data)
  );

  // output register: takes a new beat when empty or being drained
  assign res_ready = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.out_node    = out_q.out_node;
  assign result_o.out_key     = out_q.out_key;
  assign result_o.heap_empty  = out_q.heap_empty;
  assign result_o.entry_count = out_q.entry_count;
  assign result_o.status      = out_q.status;

`ifndef SYNTHESIS
  // one request at a time: ready drops right after a beat is taken
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_i.ready |=> !item_i.ready)
    else $error("request taken while one is in flight");

  // empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.heap_empty == (result_o.entry_count == '0)))
    else $error("empty flag and count disagree");

  // count never exceeds capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (32'(result_o.entry_count) <= NODES))
    else $error("entry count beyond capacity");

  // a result never arrives while the heap ram or the slot map ram is being written by the sequencer
  a_no_write_in_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !hw_en && !pw_en)
    else $error("ram write while result pending");
`endif

endmodule

[sv/ihp_ram.sv]
// generic simple dual port ram with registered read
module ihp_ram #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/ihp_ctrl.sv]
// sequencer: position lookup, sift up, raise and sift down over the two rams
module ihp_ctrl #(
  parameter int unsigned NODES = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ihp_pkg::MODE_W-1:0]    in_mode_i,
  input  logic [ihp_pkg::NODE_W-1:0]    in_node_i,
  input  logic [ihp_pkg::KEY_W-1:0]     in_key_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output ihp_pkg::res_t                 res_o,
  output logic [$clog2(NODES)-1:0]      hr_addr_o,
  input  ihp_pkg::entry_t               hr_data_i,
  output logic                          hw_en_o,
  output logic [$clog2(NODES)-1:0]      hw_addr_o,
  output ihp_pkg::entry_t               hw_data_o,
  output logic [$clog2(NODES)-1:0]      pr_addr_o,
  input  logic [$clog2(NODES):0]        pr_data_i,
  output logic                          pw_en_o,
  output logic [$clog2(NODES)-1:0]      pw_addr_o,
  output logic [$clog2(NODES):0]        pw_data_o
);

  localparam int unsigned SLOT_W = $clog2(NODES);
  localparam int unsigned CNT_W  = $clog2(NODES + 1);
  localparam int unsigned IW     = SLOT_W + 2;

  typedef struct packed {
    logic              present;
    logic [SLOT_W-1:0] slot;
  } pos_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LOOK, S_UP, S_UPFIN, S_RKEY, S_RAISE,
    S_REMROOT, S_LAST, S_DNL, S_DNR, S_DNPUT, S_RESP
  } state_e;

  state_e                     state_q, state_d;
  logic [SLOT_W-1:0]          clr_q, clr_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  ihp_pkg::entry_t            top_q;
  ihp_pkg::entry_t            cur_q, cur_d;
  ihp_pkg::entry_t            left_q, left_d;
  logic [SLOT_W-1:0]          i_q, i_d;
  ihp_pkg::mode_e             mode_q, mode_d;
  logic [ihp_pkg::NODE_W-1:0] rn_q, rn_d;
  logic [ihp_pkg::KEY_W-1:0]  rk_q, rk_d;
  logic                       removed_q, removed_d;
  ihp_pkg::status_e           st_q, st_d;

  pos_t                       pos_rd;
  pos_t                       pos_wr;
  logic [IW-1:0]              cnt_w, r_w, lc_w;
  ihp_pkg::entry_t            dn_left, child;
  logic                       dn_go, dn_rv, take_l, take_r;
  logic [SLOT_W-1:0]          cslot, par;

  function automatic logic [SLOT_W-1:0] parent_of(input logic [SLOT_W-1:0] s);
    return (s - 1'b1) >> 1;
  endfunction

  assign pos_rd    = pos_t'(pr_data_i);
  assign pw_data_o = pos_wr;
  assign cnt_w     = IW'(cnt_q);
  assign r_w       = {1'b0, i_q, 1'b0} + IW'(2);
  assign par       = parent_of(i_q);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    left_d    = left_q;
    i_d       = i_q;
    mode_d    = mode_q;
    rn_d      = rn_q;
    rk_d      = rk_q;
    removed_d = removed_q;
    st_d      = st_q;
    hr_addr_o = '0;
    hw_en_o   = 1'b0;
    hw_addr_o = i_q;
    hw_data_o = cur_q;
    pr_addr_o = '0;
    pw_en_o   = 1'b0;
    pw_addr_o = SLOT_W'(cur_q.node);
    pos_wr    = '{present: 1'b1, slot: i_q};
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    // sift down decision, from the left child alone or from both
    dn_go   = (state_q == S_DNL && !(r_w < cnt_w)) || state_q == S_DNR;
    dn_rv   = (state_q == S_DNR);
    dn_left = (state_q == S_DNR) ? left_q : hr_data_i;
    take_l  = dn_left.key > cur_q.key;
    take_r  = dn_rv && (hr_data_i.key > (take_l ? dn_left.key : cur_q.key));
    child   = take_r ? hr_data_i : dn_left;
    cslot   = take_r ? SLOT_W'(r_w) : SLOT_W'(r_w - IW'(1));
    lc_w    = {1'b0, cslot, 1'b1};

    unique case (state_q)
      S_CLR: begin
        pw_en_o   = 1'b1;
        pw_addr_o = clr_q;
        pos_wr    = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == SLOT_W'(NODES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d    = ihp_pkg::mode_e'(in_mode_i);
          cur_d     = '{node: in_node_i, key: in_key_i};
          rn_d      = in_node_i;
          removed_d = 1'b0;
          st_d      = ihp_pkg::ST_OK;
          unique case (ihp_pkg::mode_e'(in_mode_i))
            ihp_pkg::MODE_INSERT, ihp_pkg::MODE_REMOVE: begin
              if (32'(in_node_i) < NODES) begin
                pr_addr_o = SLOT_W'(in_node_i);
                state_d   = S_LOOK;
              end else begin
                st_d    = ihp_pkg::ST_ABSENT;
                state_d = S_RESP;
              end
            end
            ihp_pkg::MODE_EXTRACT: begin
              if (cnt_q == '0) begin
                st_d    = ihp_pkg::ST_EMPTY;
                state_d = S_RESP;
              end else begin
                rn_d      = top_q.node;
                rk_d      = top_q.key;
                removed_d = 1'b1;
                state_d   = S_REMROOT;
              end
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_LOOK: begin
        if (mode_q == ihp_pkg::MODE_INSERT) begin
          if (pos_rd.present) begin
            st_d    = ihp_pkg::ST_DUP;
            state_d = S_RESP;
          end else if (cnt_q >= CNT_W'(NODES)) begin
            st_d    = ihp_pkg::ST_FULL;
            state_d = S_RESP;
          end else begin
            i_d   = SLOT_W'(cnt_q);
            cnt_d = cnt_q + 1'b1;
            if (cnt_q == '0) begin
              state_d = S_UPFIN;
            end else begin
              hr_addr_o = parent_of(SLOT_W'(cnt_q));
              state_d   = S_UP;
            end
          end
        end else begin
          if (!pos_rd.present || cnt_q == '0) begin
            st_d    = ihp_pkg::ST_ABSENT;
            state_d = S_RESP;
          end else begin
            i_d       = pos_rd.slot;
            removed_d = 1'b1;
            hr_addr_o = pos_rd.slot;
            state_d   = S_RKEY;
          end
        end
      end
      S_UP: begin
        if (hr_data_i.key < cur_q.key) begin
          // parent moves down into the hole
          hw_en_o   = 1'b1;
          hw_data_o = hr_data_i;
          pw_en_o   = 1'b1;
          pw_addr_o = SLOT_W'(hr_data_i.node);
          i_d       = par;
          if (par == '0) begin
            state_d = S_UPFIN;
          end else begin
            hr_addr_o = parent_of(par);
          end
        end else begin
          hw_en_o = 1'b1;
          pw_en_o = 1'b1;
          state_d = S_RESP;
        end
      end
      S_UPFIN, S_DNPUT: begin
        hw_en_o = 1'b1;
        pw_en_o = 1'b1;
        state_d = S_RESP;
      end
      S_RKEY: begin
        rk_d = hr_data_i.key;
        if (i_q == '0) begin
          state_d = S_REMROOT;
        end else begin
          hr_addr_o = par;
          state_d   = S_RAISE;
        end
      end
      S_RAISE: begin
        hw_en_o   = 1'b1;
        hw_data_o = hr_data_i;
        pw_en_o   = 1'b1;
        pw_addr_o = SLOT_W'(hr_data_i.node);
        i_d       = par;
        if (par == '0) begin
          state_d = S_REMROOT;
        end else begin
          hr_addr_o = parent_of(par);
        end
      end
      S_REMROOT: begin
        pw_en_o   = 1'b1;
        pw_addr_o = SLOT_W'(rn_q);
        pos_wr    = '0;
        cnt_d     = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          state_d = S_RESP;
        end else begin
          hr_addr_o = SLOT_W'(cnt_q - 1'b1);
          state_d   = S_LAST;
        end
      end
      S_LAST: begin
        cur_d = hr_data_i;
        i_d   = '0;
        if (cnt_q > CNT_W'(1)) begin
          hr_addr_o = SLOT_W'(1);
          state_d   = S_DNL;
        end else begin
          state_d = S_DNPUT;
        end
      end
      S_DNL, S_DNR: begin
        left_d = dn_left;
        if (!dn_go) begin
          hr_addr_o = SLOT_W'(r_w);
          state_d   = S_DNR;
        end else if (!take_l && !take_r) begin
          hw_en_o = 1'b1;
          pw_en_o = 1'b1;
          state_d = S_RESP;
        end else begin
          // larger child moves up into the hole
          hw_en_o   = 1'b1;
          hw_data_o = child;
          pw_en_o   = 1'b1;
          pw_addr_o = SLOT_W'(child.node);
          i_d       = cslot;
          if (lc_w < cnt_w) begin
            hr_addr_o = SLOT_W'(lc_w);
            state_d   = S_DNL;
          end else begin
            state_d = S_DNPUT;
          end
        end
      end
      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (removed_q) begin
      res_o.out_node = rn_q;
      res_o.out_key  = rk_q;
    end else if (cnt_q != '0) begin
      res_o.out_node = top_q.node;
      res_o.out_key  = top_q.key;
    end else begin
      res_o.out_node = '0;
      res_o.out_key  = '0;
    end
    res_o.heap_empty  = (cnt_q == '0);
    res_o.entry_count = ihp_pkg::CNT_OUT_W'(cnt_q);
    res_o.status      = st_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_q     <= '0;
      cnt_q     <= '0;
      removed_q <= 1'b0;
      st_q      <= ihp_pkg::ST_OK;
      mode_q    <= ihp_pkg::MODE_NONE;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      cnt_q     <= cnt_d;
      removed_q <= removed_d;
      st_q      <= st_d;
      mode_q    <= mode_d;
    end
  end

  // datapath registers, root copy follows every write of slot zero
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    left_q <= left_d;
    i_q    <= i_d;
    rn_q   <= rn_d;
    rk_q   <= rk_d;
    if (hw_en_o && hw_addr_o == '0) begin
      top_q <= hw_data_o;
    end
  end

endmodule

[verif/indexed_max_heap_tb.sv]
// self-checking testbench of the indexed max heap: directed cases, a deep fill and random traffic
module indexed_max_heap_tb;

  localparam int HEAP_SLOTS  = 4096;
  localparam int FILL_COUNT  = 120;
  localparam int STALL_LIMIT = 20000;  // covers the slot map clearing pass after reset

  logic clk_i;
  logic rst_ni;

  ihp_in_if  req_if ();
  ihp_out_if res_if ();

  indexed_max_heap dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (req_if),
    .result_o (res_if)
  );

  // clock: period 20
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // shadow copy of the heap
  logic [ihp_pkg::NODE_W-1:0] shadow_node [HEAP_SLOTS];
  logic [ihp_pkg::KEY_W-1:0]  shadow_key  [HEAP_SLOTS];
  bit                         node_held   [HEAP_SLOTS];
  int unsigned                node_slot   [HEAP_SLOTS];
  int unsigned                held;

  ihp_pkg::res_t pending_results [$];
  int            mismatches;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            quiet_cycles;

  // exchange two slots and keep the slot map in step
  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [ihp_pkg::NODE_W-1:0] tn;
    logic [ihp_pkg::KEY_W-1:0]  tk;
    tn = shadow_node[a];
    tk = shadow_key[a];
    shadow_node[a] = shadow_node[b];
    shadow_key[a]  = shadow_key[b];
    shadow_node[b] = tn;
    shadow_key[b]  = tk;
    node_slot[shadow_node[a]] = a;
    node_slot[shadow_node[b]] = b;
  endfunction

  // climb only past a strictly smaller parent
  function automatic void climb(int unsigned i);
    int unsigned p;
    while (i != 0) begin
      p = (i - 1) / 2;
      if (!(shadow_key[p] < shadow_key[i])) break;
      swap_slots(i, p);
      i = p;
    end
  endfunction

  // descend only to a strictly larger child, left first
  function automatic void descend(int unsigned i);
    int unsigned l, r, big;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      big = i;
      if (l < held && shadow_key[l] > shadow_key[i]) big = l;
      if (r < held && shadow_key[r] > shadow_key[big]) big = r;
      if (big == i) break;
      swap_slots(i, big);
      i = big;
    end
  endfunction

  function automatic void drop_root();
    int unsigned last;
    last = held - 1;
    node_held[shadow_node[0]] = 1'b0;
    if (last != 0) begin
      shadow_node[0] = shadow_node[last];
      shadow_key[0]  = shadow_key[last];
      node_slot[shadow_node[0]] = 0;
    end
    held = last;
    if (held != 0) descend(0);
  endfunction

  // expected result beat of one request, updating the shadow heap
  function automatic ihp_pkg::res_t heap_step(ihp_pkg::mode_e m,
                                              logic [ihp_pkg::NODE_W-1:0] id,
                                              logic [ihp_pkg::KEY_W-1:0] k);
    ihp_pkg::res_t r;
    bit            taken;
    int unsigned   s;
    r = '0;
    r.status = ihp_pkg::ST_OK;
    taken = 1'b0;
    case (m)
      ihp_pkg::MODE_INSERT: begin
        if (node_held[id]) begin
          r.status = ihp_pkg::ST_DUP;
        end else if (held >= HEAP_SLOTS) begin
          r.status = ihp_pkg::ST_FULL;
        end else begin
          s = held;
          shadow_node[s] = id;
          shadow_key[s]  = k;
          node_slot[id]  = s;
          node_held[id]  = 1'b1;
          held = s + 1;
          climb(s);
        end
      end
      ihp_pkg::MODE_EXTRACT: begin
        if (held == 0) begin
          r.status = ihp_pkg::ST_EMPTY;
        end else begin
          r.out_node = shadow_node[0];
          r.out_key  = shadow_key[0];
          taken = 1'b1;
          drop_root();
        end
      end
      ihp_pkg::MODE_REMOVE: begin
        if (!node_held[id] || held == 0) begin
          r.status = ihp_pkg::ST_ABSENT;
        end else begin
          s = node_slot[id];
          r.out_node = id;
          r.out_key  = shadow_key[s];
          // forced to the top regardless of keys
          while (s != 0) begin
            swap_slots(s, (s - 1) / 2);
            s = (s - 1) / 2;
          end
          taken = 1'b1;
          drop_root();
        end
      end
      default: ;
    endcase
    if (!taken && held != 0) begin
      r.out_node = shadow_node[0];
      r.out_key  = shadow_key[0];
    end
    r.heap_empty  = (held == 0);
    r.entry_count = held[ihp_pkg::CNT_OUT_W-1:0];
    return r;
  endfunction

  // send one request beat; valid stays high between back-to-back beats
  task automatic send_request(ihp_pkg::mode_e m, logic [ihp_pkg::NODE_W-1:0] id,
                              logic [ihp_pkg::KEY_W-1:0] k);
    ihp_pkg::res_t want;
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.mode    <= m;
    req_if.node_id <= id;
    req_if.key     <= k;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    want = heap_step(m, id, k);
    pending_results = {pending_results, want};
  endtask

  // hold off until every expected beat has come back
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // empty heap: extract, remove and the unused mode
  task automatic test_empty_heap();
    send_request(ihp_pkg::MODE_EXTRACT, '0, '0);
    send_request(ihp_pkg::MODE_REMOVE, 12'd5, '0);
    send_request(ihp_pkg::MODE_NONE, 12'hfff, 16'hffff);
  endtask

  // field extremes, ties, duplicates, removal of the root, a leaf and the last entry
  task automatic test_directed();
    send_request(ihp_pkg::MODE_INSERT, 12'd0, 16'h0000);
    send_request(ihp_pkg::MODE_INSERT, 12'hfff, 16'hffff);
    send_request(ihp_pkg::MODE_INSERT, 12'h555, 16'h5555);
    send_request(ihp_pkg::MODE_INSERT, 12'haaa, 16'haaaa);
    send_request(ihp_pkg::MODE_INSERT, 12'h123, 16'haaaa);   // tie with an existing key
    send_request(ihp_pkg::MODE_INSERT, 12'hfff, 16'h0001);   // already present
    send_request(ihp_pkg::MODE_NONE, 12'h0, 16'h0);
    send_request(ihp_pkg::MODE_REMOVE, 12'h777, '0);         // absent node
    send_request(ihp_pkg::MODE_REMOVE, 12'd0, '0);           // deepest leaf
    send_request(ihp_pkg::MODE_REMOVE, 12'hfff, '0);         // current root
    send_request(ihp_pkg::MODE_EXTRACT, '0, '0);
    send_request(ihp_pkg::MODE_EXTRACT, '0, '0);
    send_request(ihp_pkg::MODE_REMOVE, 12'h555, '0);         // last entry leaves
    send_request(ihp_pkg::MODE_INSERT, 12'h555, 16'h0042);   // its slot entry must be clear
    send_request(ihp_pkg::MODE_EXTRACT, '0, '0);
    send_request(ihp_pkg::MODE_EXTRACT, '0, '0);             // empty again
  endtask

  // deep fill, duplicate errors and random removes, then empty it again
  task automatic test_deep_fill();
    for (int i = 0; i < FILL_COUNT; i++) begin
      send_request(ihp_pkg::MODE_INSERT, i[ihp_pkg::NODE_W-1:0],
                   ihp_pkg::KEY_W'($urandom));
    end
    send_request(ihp_pkg::MODE_INSERT, 12'd7, 16'h1234);     // already present
    drain();
    send_request(ihp_pkg::MODE_INSERT, 12'd7, 16'h1234);
    for (int i = 0; i < 40; i++) begin
      send_request(ihp_pkg::MODE_REMOVE, ihp_pkg::NODE_W'($urandom_range(FILL_COUNT + 20)),
                   '0);
    end
    while (held != 0) send_request(ihp_pkg::MODE_EXTRACT, '0, '0);
  endtask

  // random traffic: mostly valid operations on a small heap, some errors mixed in
  task automatic test_random(int count);
    int unsigned                pick;
    logic [ihp_pkg::NODE_W-1:0] id;
    logic [ihp_pkg::KEY_W-1:0]  k;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      id   = ihp_pkg::NODE_W'($urandom);
      k    = $urandom_range(1) ? ihp_pkg::KEY_W'($urandom) : ihp_pkg::KEY_W'($urandom_range(7));
      if (held > 60 && pick < 45) pick = 50;
      if (pick < 45) begin
        send_request(ihp_pkg::MODE_INSERT, id, k);
      end else if (pick < 70) begin
        send_request(ihp_pkg::MODE_EXTRACT, id, k);
      end else if (pick < 90 && held != 0) begin
        send_request(ihp_pkg::MODE_REMOVE, shadow_node[$urandom_range(held - 1)], k);
      end else if (pick < 94) begin
        send_request(ihp_pkg::MODE_REMOVE, id, k);
      end else if (pick < 97 && held != 0) begin
        send_request(ihp_pkg::MODE_INSERT, shadow_node[$urandom_range(held - 1)], k);
      end else begin
        send_request(ihp_pkg::MODE_NONE, id, k);
      end
    end
  endtask

  // receiver stalls at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each result beat with the oldest expected one
  always @(posedge clk_i) begin
    ihp_pkg::res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with none expected");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (res_if.out_node !== want.out_node) begin
          $error("out_node: expected %0d, got %0d", want.out_node, res_if.out_node);
          mismatches++;
        end
        if (res_if.out_key !== want.out_key) begin
          $error("out_key: expected %0d, got %0d", want.out_key, res_if.out_key);
          mismatches++;
        end
        if (res_if.heap_empty !== want.heap_empty) begin
          $error("heap_empty: expected %0d, got %0d", want.heap_empty, res_if.heap_empty);
          mismatches++;
        end
        if (res_if.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, res_if.entry_count);
          mismatches++;
        end
        if (res_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_if.status);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long without any beat on either side
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.mode    = ihp_pkg::MODE_NONE;
    req_if.node_id = '0;
    req_if.key     = '0;
    mismatches     = 0;
    quiet_cycles   = 0;
    held           = 0;
    send_idle_pct  = 7;
    recv_stall_pct = 55;
    for (int i = 0; i < HEAP_SLOTS; i++) node_held[i] = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_heap();
    test_directed();
    drain();
    test_random(420);
    drain();
    send_idle_pct  = 55;
    recv_stall_pct = 7;
    test_random(420);
    test_deep_fill();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random(420);
    drain();
    repeat (60) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
